// ===== src/iqr_pkg.sv =====
package iqr_pkg;

  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 24;
  localparam int FIELD_W     = 24;
  localparam int CFG_W       = 24;
  localparam int UCFG_W      = 23;
  localparam int FRAC_BITS   = 16;
  localparam int MIN_SAMPLES = 4;

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + CFG_W;
  localparam int WGT_W  = PROD_W - FRAC_BITS + 1;
  localparam int FENCE_W = SAMPLE_BITS + 3;

  localparam logic [2:0] CFG_TARE      = 3'd0;
  localparam logic [2:0] CFG_GAIN      = 3'd1;
  localparam logic [2:0] CFG_INTERCEPT = 3'd2;
  localparam logic [2:0] CFG_MAX_WGT   = 3'd3;
  localparam logic [2:0] CFG_MIN_WGT   = 3'd4;
  localparam logic [2:0] CFG_MIN_CHG   = 3'd5;

  localparam logic [1:0] ST_NOT_READY    = 2'd0;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd1;
  localparam logic [1:0] ST_CHANGE_SMALL = 2'd2;
  localparam logic [1:0] ST_REPORT       = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic rotate;
  } row_ctl_t;

  localparam logic signed [WGT_W-1:0] SAT_HI = WGT_W'(8388607);
  localparam logic signed [WGT_W-1:0] SAT_LO = -WGT_W'(8388608);

  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [WGT_W-1:0] x);
    logic signed [WGT_W-1:0] y;
    y = x;
    if (x > SAT_HI) y = SAT_HI;
    if (x < SAT_LO) y = SAT_LO;
    return y[FIELD_W-1:0];
  endfunction

endpackage

// ===== src/iqr_ifs.sv =====
interface iqr_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [23:0]       raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface iqr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [23:0] weight_mg;
  logic signed [23:0] median_val;
  logic [3:0]         inliers_used;
  logic [3:0]         samples_held;
  modport source (output valid, output status, output weight_mg, output median_val,
                  output inliers_used, output samples_held, input ready);
  modport sink   (input valid, input status, input weight_mg, input median_val,
                  input inliers_used, input samples_held, output ready);
endinterface

// ===== src/iqr_ram.sv =====
module iqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/iqr_sort_row.sv =====
module iqr_sort_row
  import iqr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  row_ctl_t ctl,
  input  sample_t  key,
  output sample_t  head
);
  sample_t          cells [WINDOW];
  logic [CNT_W-1:0] fill;

  assign head = cells[0];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      fill <= '0;
    end else if (ctl.insert) begin
      fill <= fill + CNT_W'(1);
    end
  end

  // ordered insert: every cell above the key's slot moves up by one
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      for (int k = 0; k < WINDOW; k++) begin
        if (CNT_W'(k) < fill) begin
          if (cells[k] > key) begin
            if (k > 0 && cells[(k > 0) ? k - 1 : 0] > key) cells[k] <= cells[(k > 0) ? k - 1 : 0];
            else cells[k] <= key;
          end
        end else if (CNT_W'(k) == fill) begin
          if (k > 0 && cells[(k > 0) ? k - 1 : 0] > key) cells[k] <= cells[(k > 0) ? k - 1 : 0];
          else cells[k] <= key;
        end
      end
    end else if (ctl.rotate) begin
      for (int k = 0; k < WINDOW - 1; k++) cells[k] <= cells[k + 1];
      cells[WINDOW-1] <= cells[0];
    end
  end
endmodule

// ===== src/iqr_median_weigh_filter_core.sv =====
// Processing: one item at a time; with n samples held (n >= 4), an accepted sample is
//   written and all n held samples are loaded into the sorted row; three passes over the row
//   find the quartiles, count the entries against the fences and pick the median before the
//   weight is computed; under 4 samples the result goes straight to the output stage.
//   A result held at the output stalls the input.
// Reset: control, window count, last report and configuration go to their defaults;
//   the sample memory is not cleared, its entries are read only after being written.
module iqr_median_weigh_filter_core
  import iqr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  iqr_in_if.sink             sample_in,
  iqr_out_if.source          result_out
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_QUART = 4'd2;
  localparam logic [3:0] S_FENCE = 4'd3;
  localparam logic [3:0] S_COUNT = 4'd4;
  localparam logic [3:0] S_MED   = 4'd5;
  localparam logic [3:0] S_AVG   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_CAL   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state;

  logic signed [CFG_W-1:0]  tare, gain, intercept, min_w;
  logic [UCFG_W-1:0]        max_w, min_chg;

  logic [IDX_W-1:0] write_slot;
  logic             window_full;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] i;
  logic             rd_pend;
  logic             nr;

  sample_t q1, q3, m_lo, m_hi, med;
  logic signed [FENCE_W-1:0] lo, hi;
  logic [CNT_W-1:0] below, in_cnt, base, used;
  logic signed [PROD_W-1:0] prod;
  logic signed [WGT_W-1:0]  w;
  logic signed [FIELD_W-1:0] last_rep;
  logic has_reported;

  logic out_valid;
  logic [1:0] o_status;
  logic signed [FIELD_W-1:0] o_weight, o_median;
  logic [CNT_W-1:0] o_used, o_held;

  logic in_ok, load_ok;
  logic [CNT_W-1:0] n_new;
  sample_t ram_q, head;
  row_ctl_t row_ctl;

  assign in_ok   = sample_in.valid && sample_in.ready;
  assign load_ok = !out_valid || result_out.ready;
  assign sample_in.ready = (state == S_IDLE);
  assign n_new = (window_full || write_slot == IDX_W'(WINDOW - 1)) ? CNT_W'(WINDOW)
                 : CNT_W'(write_slot) + CNT_W'(1);

  iqr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_win (
    .clk   (clk),
    .we    (in_ok),
    .waddr (write_slot),
    .wdata (SAMPLE_BITS'(sample_in.raw_sample)),
    .raddr (i[IDX_W-1:0]),
    .rdata (ram_q)
  );

  assign row_ctl.clear  = in_ok;
  assign row_ctl.insert = (state == S_LOAD) && rd_pend;
  assign row_ctl.rotate = (state == S_QUART) || (state == S_COUNT) || (state == S_MED);

  iqr_sort_row u_row (
    .clk  (clk),
    .rst  (rst),
    .ctl  (row_ctl),
    .key  (ram_q),
    .head (head)
  );

  // quartile and median positions
  logic [CNT_W+1:0] n3;
  logic [CNT_W-1:0] q1i, q3i, idx_hi, idx_lo;
  assign n3     = {2'b00, n} + {1'b0, n, 1'b0};
  assign q1i    = n >> 2;
  assign q3i    = n3[CNT_W+1:2];
  assign idx_hi = base + (used >> 1);
  assign idx_lo = idx_hi - CNT_W'(1);

  logic signed [SAMPLE_BITS:0] d_q, sum, sum_adj;
  logic signed [FENCE_W-1:0]   off;
  assign d_q     = (SAMPLE_BITS+1)'(q3) - (SAMPLE_BITS+1)'(q1);
  assign off     = FENCE_W'(d_q) + FENCE_W'(d_q >>> 1);
  assign sum     = (SAMPLE_BITS+1)'(m_lo) + (SAMPLE_BITS+1)'(m_hi);
  assign sum_adj = sum + (SAMPLE_BITS+1)'({1'b0, sum[SAMPLE_BITS]});

  // classify the entry at the head, counting the current one in the totals
  logic cnt_valid, is_below, is_in;
  logic [CNT_W-1:0] below_next, in_next;
  assign cnt_valid  = (i < n);
  assign is_below   = cnt_valid && (FENCE_W'(head) < lo);
  assign is_in      = cnt_valid && !is_below && (FENCE_W'(head) <= hi);
  assign below_next = below + CNT_W'(is_below);
  assign in_next    = in_cnt + CNT_W'(is_in);

  logic signed [DIFF_W-1:0] diff;
  assign diff = DIFF_W'(med) - DIFF_W'(tare);

  logic w_out, chg_small;
  logic signed [WGT_W:0] dl, dabs;
  logic [1:0] status_c;
  assign w_out = (w < WGT_W'(min_w)) || (w > $signed(WGT_W'(max_w)));
  assign dl    = (WGT_W+1)'(w) - (WGT_W+1)'(last_rep);
  assign dabs  = dl[WGT_W] ? -dl : dl;
  assign chg_small = has_reported && (dabs < $signed((WGT_W+1)'(min_chg)));
  assign status_c  = w_out ? ST_OUT_OF_RANGE : (chg_small ? ST_CHANGE_SMALL : ST_REPORT);

  always_ff @(posedge clk) begin
    if (rst) begin
      tare <= '0;
      gain <= -CFG_W'(157670);
      intercept <= -CFG_W'(1373800);
      max_w <= UCFG_W'(5000000);
      min_w <= -CFG_W'(10000);
      min_chg <= UCFG_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARE:      tare <= cfg_data;
        CFG_GAIN:      gain <= cfg_data;
        CFG_INTERCEPT: intercept <= cfg_data;
        CFG_MAX_WGT:   max_w <= cfg_data[UCFG_W-1:0];
        CFG_MIN_WGT:   min_w <= cfg_data;
        CFG_MIN_CHG:   min_chg <= cfg_data[UCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      write_slot <= '0;
      window_full <= 1'b0;
      has_reported <= 1'b0;
      last_rep <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
      nr <= 1'b0;
      i <= '0;
      n <= '0;
    end else begin
      if (state == S_OUT && load_ok) out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ok) begin
            write_slot <= (write_slot == IDX_W'(WINDOW - 1)) ? '0 : write_slot + IDX_W'(1);
            if (write_slot == IDX_W'(WINDOW - 1)) window_full <= 1'b1;
            n <= n_new;
            i <= '0;
            rd_pend <= 1'b0;
            nr <= (n_new < CNT_W'(MIN_SAMPLES));
            state <= (n_new < CNT_W'(MIN_SAMPLES)) ? S_OUT : S_LOAD;
          end
        end
        S_LOAD: begin
          rd_pend <= (i < n);
          if (i == n) begin
            i <= '0;
            state <= S_QUART;
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        S_QUART: begin
          if (i == q1i) q1 <= head;
          if (i == q3i) q3 <= head;
          if (i == CNT_W'(WINDOW - 1)) begin
            i <= '0;
            state <= S_FENCE;
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        S_FENCE: begin
          lo <= FENCE_W'(q1) - off;
          hi <= FENCE_W'(q3) + off;
          below <= '0;
          in_cnt <= '0;
          state <= S_COUNT;
        end
        S_COUNT: begin
          below <= below_next;
          in_cnt <= in_next;
          if (i == CNT_W'(WINDOW - 1)) begin
            // no inlier at all: fall back to the whole window
            base <= (in_next == '0) ? '0 : below_next;
            used <= (in_next == '0) ? n : in_next;
            i <= '0;
            state <= S_MED;
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        S_MED: begin
          if (i == idx_hi) m_hi <= head;
          if (i == idx_lo) m_lo <= head;
          if (i == CNT_W'(WINDOW - 1)) begin
            i <= '0;
            state <= S_AVG;
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        S_AVG: begin
          med <= used[0] ? m_hi : SAMPLE_BITS'(sum_adj >>> 1);
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= PROD_W'(diff) * PROD_W'(gain);
          state <= S_CAL;
        end
        S_CAL: begin
          w <= WGT_W'($signed(prod[PROD_W-1:FRAC_BITS])) + WGT_W'(intercept);
          state <= S_OUT;
        end
        S_OUT: begin
          if (load_ok) begin
            o_held <= n;
            if (nr) begin
              o_status <= ST_NOT_READY;
              o_weight <= '0;
              o_median <= '0;
              o_used <= '0;
            end else begin
              o_status <= status_c;
              o_weight <= sat_field(w);
              o_median <= sat_field(WGT_W'(med));
              o_used <= used;
              if (status_c == ST_REPORT) begin
                last_rep <= w[FIELD_W-1:0];
                has_reported <= 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.status       = o_status;
  assign result_out.weight_mg    = o_weight;
  assign result_out.median_val   = o_median;
  assign result_out.inliers_used = 4'(o_used);
  assign result_out.samples_held = 4'(o_held);

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_ok |=> (state == S_LOAD || state == S_OUT))
    else $error("accepted sample did not start processing");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && load_ok) |=> (state == S_IDLE && out_valid))
    else $error("result not presented after output stage");

  a_report_mark: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && load_ok && !nr && status_c == ST_REPORT) |=> has_reported)
    else $error("report did not set report flag");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    in_ok |=> (n <= CNT_W'(WINDOW) && n != '0))
    else $error("window count out of bounds");
endmodule
